// ===== rtl/core/bngp_pkg.sv =====
// Shared types and constants for the byte n-gram packer.
// Used by bngp_regs and byte_ngram_packer_core; no dependencies.
`default_nettype none

package bngp_pkg;

  // Fixed field widths
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned GRAM_BYTES = 8;
  localparam int unsigned GRAM_W     = GRAM_BYTES * BYTE_W;
  localparam int unsigned KIND_W     = 2;

  // Configuration port
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned REG_IDX_W  = 3;

  // Parameter defaults
  localparam int unsigned MAX_WINDOW_DEF = 8;
  localparam int unsigned POS_BITS_DEF   = 16;

  // Skipped-line counter stops here
  localparam logic [BYTE_W-1:0] SKIP_CNT_MAX = 8'hFF;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ID   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GRAM = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EOL  = 2'd2;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEN = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SKIP_LINES = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HAS_ID     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TAIL_FLUSH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LINE_END   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FIELD_SEP  = 3'd5;

  typedef struct packed {
    logic [LEN_W-1:0]  window_len;
    logic [BYTE_W-1:0] skip_lines;
    logic              has_id;
    logic              tail_flush;
    logic [BYTE_W-1:0] line_end;
    logic [BYTE_W-1:0] field_sep;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/byte_ngram_packer_core.sv =====
// Byte n-gram packer top level: line/ID parsing, sliding window, output register.
// Depends on bngp_pkg and bngp_regs.
//
// Usage:
//   Input channel: one text byte per beat (in_byte_i), in_valid_i / in_stall_o.
//   Output channel: one result per beat (kind, out_byte, position, gram_value,
//   last), out_valid_o / out_stall_i. last marks the final result of a byte.
//   Configuration is written over the APB-style port while the block is idle.
//   Output: a result is registered and appears in the cycle after its byte is taken.
//   Throughput: one byte per cycle while the output is not stalled. A line end
//   with tail flush gives n results (n-1 tail grams and the end marker), one
//   per cycle from the output register while it is not stalled; the input
//   stalls until the last of them is taken, n being the effective window length.
//   Bytes that give no result (skipped lines, the ID separator, a window not
//   yet full) are taken without sending an output beat.
//   Stall: the single output register holds its beat while out_stall_i is
//   high; the input is stalled while that register is full and cannot drain
//   in the same cycle, and while tail beats of a line end remain to be sent.
//   Reset: configuration returns to its defaults (n=4, skip one line, ID mode,
//   no tail flush, line end 10, separator 9), line state clears, output empty.
`default_nettype none

module byte_ngram_packer_core
  import bngp_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int unsigned POS_BITS   = POS_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic      [DATA_W-1:0]   prdata,
  output logic                     pready,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [BYTE_W-1:0]   in_byte_i,
  // output channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [KIND_W-1:0]   kind_o,
  output logic      [BYTE_W-1:0]   out_byte_o,
  output logic      [POS_BITS:0]   position_o,
  output logic      [GRAM_W-1:0]   gram_value_o,
  output logic                     last_o
);

  localparam int unsigned CNT_W = POS_BITS + 1;
  localparam int unsigned SPW   = POS_BITS + 2;
  localparam int unsigned REM_W = 3;
  localparam logic [CNT_W-1:0] POS_MAX = {1'b0, {POS_BITS{1'b1}}};
  localparam logic [CNT_W-1:0] CNT_MAX = POS_MAX + CNT_W'(MAX_WINDOW);

  // Saturate a signed tail position and fold it into the output field
  function automatic logic [POS_BITS:0] enc_pos(input logic signed [SPW-1:0] p);
    logic signed [SPW-1:0] top;
    top = $signed({1'b0, POS_MAX});
    if (p > top) enc_pos = POS_MAX;
    else         enc_pos = p[POS_BITS:0];
  endfunction

  cfg_t cfg;

  bngp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Line state
  logic [BYTE_W-1:0] lines_skipped_q, lines_skipped_d;
  logic              in_body_q, in_body_d;
  logic [GRAM_W-1:0] window_q, window_d;
  logic [CNT_W-1:0]  body_count_q, body_count_d;

  // Output register and tail sequencer
  logic                  out_valid_q, out_valid_d;
  logic [KIND_W-1:0]     kind_q, kind_d;
  logic [BYTE_W-1:0]     out_byte_q, out_byte_d;
  logic [POS_BITS:0]     position_q, position_d;
  logic [GRAM_W-1:0]     gram_q, gram_d;
  logic                  last_q, last_d;
  logic [REM_W-1:0]      tail_rem_q, tail_rem_d;
  logic [GRAM_W-1:0]     tail_w_q, tail_w_d;
  logic signed [SPW-1:0] tail_pos_q, tail_pos_d;

  // Handshake
  logic accept, out_fire, tail_busy, out_free;
  assign tail_busy  = (tail_rem_q != '0);
  assign out_fire   = out_valid_q & ~out_stall_i;
  assign out_free   = ~out_valid_q | (out_fire & ~tail_busy);
  assign in_stall_o = ~out_free;
  assign accept     = in_valid_i & out_free;

  // Effective window length
  logic [LEN_W-1:0] n_eff;
  always_comb begin
    if (cfg.window_len == '0)                   n_eff = LEN_W'(1);
    else if (cfg.window_len > LEN_W'(MAX_WINDOW)) n_eff = LEN_W'(MAX_WINDOW);
    else                                        n_eff = cfg.window_len;
  end

  // Window masked to n bytes, and the window with the new byte shifted in
  logic [GRAM_W-1:0] win_masked, win_shift, win_next;
  always_comb begin
    for (int i = 0; i < GRAM_BYTES; i++) begin
      win_masked[i*BYTE_W +: BYTE_W] =
        (LEN_W'(i) < n_eff) ? window_q[i*BYTE_W +: BYTE_W] : '0;
    end
    win_shift = win_masked >> BYTE_W;
    win_next  = win_shift;
    for (int i = 0; i < GRAM_BYTES; i++) begin
      if (LEN_W'(i + 1) == n_eff) win_next[i*BYTE_W +: BYTE_W] = in_byte_i;
    end
  end

  // Body count and positions
  logic [CNT_W-1:0]      bc_inc, gram_off;
  logic [POS_BITS:0]     gram_pos;
  logic signed [SPW-1:0] tail_p0;
  always_comb begin
    bc_inc   = (body_count_q < CNT_MAX) ? body_count_q + CNT_W'(1) : body_count_q;
    gram_off = bc_inc - CNT_W'(n_eff);
    gram_pos = (gram_off > POS_MAX) ? POS_MAX : gram_off;
    tail_p0  = $signed({1'b0, body_count_q}) - $signed(SPW'(n_eff)) + SPW'(1);
  end

  // Byte classification
  logic skipping, is_le, is_sep, is_id;
  assign skipping = (lines_skipped_q < cfg.skip_lines);
  assign is_le    = (in_byte_i == cfg.line_end);
  assign is_sep   = cfg.has_id & ~in_body_q & (in_byte_i == cfg.field_sep);
  assign is_id    = cfg.has_id & ~in_body_q;

  // Per-byte step: line state and the next output beat
  always_comb begin
    lines_skipped_d = lines_skipped_q;
    in_body_d       = in_body_q;
    window_d        = window_q;
    body_count_d    = body_count_q;

    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    out_byte_d  = out_byte_q;
    position_d  = position_q;
    gram_d      = gram_q;
    last_d      = last_q;
    tail_rem_d  = tail_rem_q;
    tail_w_d    = tail_w_q;
    tail_pos_d  = tail_pos_q;

    if (out_fire && tail_busy) begin
      // next tail beat
      tail_rem_d = tail_rem_q - REM_W'(1);
      out_byte_d = '0;
      if (tail_rem_q == REM_W'(1)) begin
        kind_d     = KIND_EOL;
        position_d = '0;
        gram_d     = '0;
        last_d     = 1'b1;
      end else begin
        tail_w_d   = tail_w_q >> BYTE_W;
        tail_pos_d = tail_pos_q + SPW'(1);
        kind_d     = KIND_GRAM;
        position_d = enc_pos(tail_pos_q + SPW'(1));
        gram_d     = tail_w_q >> BYTE_W;
        last_d     = 1'b0;
      end
    end else if (out_free) begin
      out_valid_d = 1'b0;
      if (accept) begin
        out_byte_d = '0;
        position_d = '0;
        gram_d     = '0;
        last_d     = 1'b1;
        if (skipping) begin
          if (is_le && lines_skipped_q < SKIP_CNT_MAX) begin
            lines_skipped_d = lines_skipped_q + BYTE_W'(1);
          end
        end else if (is_sep) begin
          in_body_d = 1'b1;
        end else if (is_le) begin
          window_d     = '0;
          body_count_d = '0;
          in_body_d    = 1'b0;
          out_valid_d  = 1'b1;
          if (cfg.tail_flush && n_eff > LEN_W'(1)) begin
            // first tail gram now, the rest from the sequencer
            kind_d     = KIND_GRAM;
            position_d = enc_pos(tail_p0);
            gram_d     = win_shift;
            last_d     = 1'b0;
            tail_rem_d = REM_W'(n_eff - LEN_W'(1));
            tail_w_d   = win_shift;
            tail_pos_d = tail_p0;
          end else begin
            kind_d = KIND_EOL;
          end
        end else if (is_id) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_ID;
          out_byte_d  = in_byte_i;
        end else begin
          // body byte
          window_d     = win_next;
          body_count_d = bc_inc;
          if (bc_inc >= CNT_W'(n_eff)) begin
            out_valid_d = 1'b1;
            kind_d      = KIND_GRAM;
            position_d  = gram_pos;
            gram_d      = win_next;
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_skipped_q <= '0;
      in_body_q       <= 1'b0;
      window_q        <= '0;
      body_count_q    <= '0;
      out_valid_q     <= 1'b0;
      tail_rem_q      <= '0;
    end else begin
      lines_skipped_q <= lines_skipped_d;
      in_body_q       <= in_body_d;
      window_q        <= window_d;
      body_count_q    <= body_count_d;
      out_valid_q     <= out_valid_d;
      tail_rem_q      <= tail_rem_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    out_byte_q <= out_byte_d;
    position_q <= position_d;
    gram_q     <= gram_d;
    last_q     <= last_d;
    tail_w_q   <= tail_w_d;
    tail_pos_q <= tail_pos_d;
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign out_byte_o   = out_byte_q;
  assign position_o   = position_q;
  assign gram_value_o = gram_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/bngp_regs.sv =====
// APB-style configuration registers of the byte n-gram packer.
// Depends on bngp_pkg for the register map and the cfg_t struct.
`default_nettype none

module bngp_regs
  import bngp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t                 cfg_q;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_o   = cfg_q;

  // Register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_len <= 4'd4;
      cfg_q.skip_lines <= 8'd1;
      cfg_q.has_id     <= 1'b1;
      cfg_q.tail_flush <= 1'b0;
      cfg_q.line_end   <= 8'd10;
      cfg_q.field_sep  <= 8'd9;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WINDOW_LEN: cfg_q.window_len <= pwdata[LEN_W-1:0];
        REG_SKIP_LINES: cfg_q.skip_lines <= pwdata[BYTE_W-1:0];
        REG_HAS_ID:     cfg_q.has_id     <= pwdata[0];
        REG_TAIL_FLUSH: cfg_q.tail_flush <= pwdata[0];
        REG_LINE_END:   cfg_q.line_end   <= pwdata[BYTE_W-1:0];
        REG_FIELD_SEP:  cfg_q.field_sep  <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_WINDOW_LEN: prdata = DATA_W'(cfg_q.window_len);
      REG_SKIP_LINES: prdata = DATA_W'(cfg_q.skip_lines);
      REG_HAS_ID:     prdata = DATA_W'(cfg_q.has_id);
      REG_TAIL_FLUSH: prdata = DATA_W'(cfg_q.tail_flush);
      REG_LINE_END:   prdata = DATA_W'(cfg_q.line_end);
      REG_FIELD_SEP:  prdata = DATA_W'(cfg_q.field_sep);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for byte_ngram_packer_core: byte stream in, n-gram records out.
// Depends on bngp_pkg and the core RTL; predicts every result beat in-line and
// compares it field by field against the DUT output.
`timescale 1ns / 1ps

module tb;
  import bngp_pkg::*;

  localparam int unsigned POS_MAX      = (1 << POS_BITS_DEF) - 1;
  localparam int unsigned BODY_CAP     = POS_MAX + MAX_WINDOW_DEF;
  localparam int unsigned WATCHDOG_MAX = 2000;
  localparam int unsigned SETTLE_CYC   = 12;
  localparam int unsigned SQUEEZE_CYC  = 200;
  localparam int unsigned RAND_PHASES  = 4;
  localparam int unsigned PHASE_BYTES  = 25;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   ob;
    logic [POS_BITS_DEF:0] pos;
    logic [GRAM_W-1:0]   gram;
    logic                last;
  } ngram_result_t;

  // DUT connections; the inputs are known from time zero
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [ADDR_W-1:0]     paddr       = '0;
  logic [DATA_W-1:0]     pwdata      = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [BYTE_W-1:0]     in_byte_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [KIND_W-1:0]     kind_o;
  logic [BYTE_W-1:0]     out_byte_o;
  logic [POS_BITS_DEF:0] position_o;
  logic [GRAM_W-1:0]     gram_value_o;
  logic                  last_o;

  // Stimulus and scoreboard state
  logic [BYTE_W-1:0] text_q[$];
  ngram_result_t     expected_q[$];
  int unsigned       bytes_queued = 0;
  int unsigned       bytes_taken  = 0;
  int unsigned       error_cnt    = 0;
  int unsigned       idle_cycles  = 0;
  logic              beat_taken   = 1'b0;
  logic              squeeze_req  = 1'b0;

  // Predictor's copy of configuration and line state
  cfg_t              cfg_mirror;
  logic [BYTE_W-1:0] lines_dropped;
  logic              in_body;
  logic [GRAM_W-1:0] window_bytes;
  int                body_len_cnt;

  byte_ngram_packer_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .out_byte_o   (out_byte_o),
    .position_o   (position_o),
    .gram_value_o (gram_value_o),
    .last_o       (last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Idle run length: mostly none or short, now and then long
  function automatic int unsigned pick_idle_len(input int unsigned long_max);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, long_max);
  endfunction

  function automatic logic [GRAM_W-1:0] gram_mask(input int n);
    if (n >= GRAM_BYTES) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic logic [POS_BITS_DEF:0] clip_pos(input int p);
    if (p > int'(POS_MAX)) p = POS_MAX;
    return p[POS_BITS_DEF:0];
  endfunction

  function automatic ngram_result_t make_result(input logic [KIND_W-1:0] kind,
                                                input logic [BYTE_W-1:0] ob,
                                                input logic [POS_BITS_DEF:0] pos,
                                                input logic [GRAM_W-1:0] gram);
    ngram_result_t r;
    r.kind = kind;
    r.ob   = ob;
    r.pos  = pos;
    r.gram = gram;
    r.last = 1'b0;
    return r;
  endfunction

  // Work out the result beats one text byte causes and queue them
  task automatic predict_results(input logic [BYTE_W-1:0] b);
    ngram_result_t     batch[$];
    int                n;
    int                p;
    logic [GRAM_W-1:0] w;
    if (cfg_mirror.window_len == 0) n = 1;
    else if (cfg_mirror.window_len > MAX_WINDOW_DEF) n = MAX_WINDOW_DEF;
    else n = cfg_mirror.window_len;

    // still dropping leading lines
    if (lines_dropped < cfg_mirror.skip_lines) begin
      if (b == cfg_mirror.line_end && lines_dropped < SKIP_CNT_MAX) lines_dropped++;
      return;
    end
    // first separator of the line is swallowed
    if (cfg_mirror.has_id && !in_body && b == cfg_mirror.field_sep) begin
      in_body = 1'b1;
      return;
    end

    if (b == cfg_mirror.line_end) begin
      // tail grams shrink one byte at a time
      if (cfg_mirror.tail_flush) begin
        w = window_bytes & gram_mask(n);
        for (int j = 0; j + 1 < n; j++) begin
          p = body_len_cnt - n + 1 + j;
          w = w >> 8;
          batch.push_back(make_result(KIND_GRAM, '0, clip_pos(p), w));
        end
      end
      batch.push_back(make_result(KIND_EOL, '0, '0, '0));
      window_bytes = '0;
      body_len_cnt = 0;
      in_body      = 1'b0;
    end else if (cfg_mirror.has_id && !in_body) begin
      batch.push_back(make_result(KIND_ID, b, '0, '0));
    end else begin
      window_bytes = ((window_bytes & gram_mask(n)) >> 8) | (64'(b) << (8 * (n - 1)));
      window_bytes = window_bytes & gram_mask(n);
      if (body_len_cnt < int'(BODY_CAP)) body_len_cnt++;
      if (body_len_cnt >= n)
        batch.push_back(make_result(KIND_GRAM, '0, clip_pos(body_len_cnt - n), window_bytes));
    end

    if (batch.size() != 0) begin
      batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) expected_q.push_back(batch[i]);
    end
  endtask

  // Sender: offers the next byte at the falling edge, holds it until taken
  int unsigned gap_left  = 0;
  int unsigned send_calm = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || beat_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (text_q.size() != 0) begin
        in_byte_i  <= text_q.pop_front();
        in_valid_i <= 1'b1;
        if (send_calm > 0) begin
          send_calm--;
          gap_left = 0;
        end else begin
          gap_left = pick_idle_len(30);
          if ($urandom_range(0, 15) == 0) send_calm = $urandom_range(20, 60);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold-off on request
  int unsigned stall_left   = 0;
  int unsigned recv_calm    = 0;
  int unsigned hold_left    = 0;
  logic        squeeze_done = 1'b0;

  always @(negedge clk_i) begin
    if (squeeze_req && !squeeze_done) begin
      hold_left    = SQUEEZE_CYC;
      squeeze_done = 1'b1;
    end
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (recv_calm > 0) begin
      recv_calm--;
      out_stall_i <= 1'b0;
    end else begin
      stall_left = pick_idle_len(40);
      if ($urandom_range(0, 15) == 0) recv_calm = $urandom_range(20, 80);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: predict on every accepted byte, check every accepted result beat
  always @(posedge clk_i) begin
    ngram_result_t exp_r;
    logic          out_taken;
    beat_taken = rst_ni && in_valid_i && !in_stall_o;
    out_taken  = rst_ni && out_valid_o && !out_stall_i;
    if (beat_taken) begin
      predict_results(in_byte_i);
      bytes_taken++;
    end
    if (out_taken) begin
      if (expected_q.size() == 0) begin
        error_cnt++;
        if (error_cnt <= 10)
          $display("unexpected beat: kind=%0d byte=%02h pos=%0d gram=%016h last=%0d",
                   kind_o, out_byte_o, $signed(position_o), gram_value_o, last_o);
      end else begin
        exp_r = expected_q.pop_front();
        if (kind_o !== exp_r.kind || out_byte_o !== exp_r.ob || position_o !== exp_r.pos ||
            gram_value_o !== exp_r.gram || last_o !== exp_r.last) begin
          error_cnt++;
          if (error_cnt <= 10)
            $display("beat mismatch: exp kind=%0d byte=%02h pos=%0d gram=%016h last=%0d",
                     exp_r.kind, exp_r.ob, $signed(exp_r.pos), exp_r.gram, exp_r.last,
                     " | got kind=%0d byte=%02h pos=%0d gram=%016h last=%0d",
                     kind_o, out_byte_o, $signed(position_o), gram_value_o, last_o);
        end
      end
    end
    if (beat_taken || out_taken) idle_cycles = 0;
    else idle_cycles++;
  end

  // Watchdog: too long without any handshake
  initial begin
    while (idle_cycles < WATCHDOG_MAX) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    text_q.push_back(b);
    bytes_queued++;
  endtask

  // Wait until every byte is taken and every result beat has arrived
  task automatic settle();
    while (bytes_taken != bytes_queued || expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // APB write: setup then access; the mirror follows the DUT register
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_WINDOW_LEN: cfg_mirror.window_len = value[LEN_W-1:0];
      REG_SKIP_LINES: cfg_mirror.skip_lines = value[BYTE_W-1:0];
      REG_HAS_ID:     cfg_mirror.has_id     = value[0];
      REG_TAIL_FLUSH: cfg_mirror.tail_flush = value[0];
      REG_LINE_END:   cfg_mirror.line_end   = value[BYTE_W-1:0];
      REG_FIELD_SEP:  cfg_mirror.field_sep  = value[BYTE_W-1:0];
      default: ;
    endcase
  endtask

  // Ordinary text byte, now and then raw noise that may hit a delimiter
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] v;
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    do v = 8'($urandom_range(0, 255));
    while (v == cfg_mirror.line_end || v == cfg_mirror.field_sep);
    return v;
  endfunction

  task automatic queue_text_line(input int unsigned id_len, input int unsigned body_len);
    if (cfg_mirror.has_id) begin
      for (int unsigned i = 0; i < id_len; i++) queue_byte(plain_byte());
      queue_byte(cfg_mirror.field_sep);
    end
    for (int unsigned i = 0; i < body_len; i++) queue_byte(plain_byte());
    queue_byte(cfg_mirror.line_end);
  endtask

  task automatic pick_random_setup();
    logic [BYTE_W-1:0] le;
    logic [BYTE_W-1:0] sep;
    int unsigned       r;
    write_reg(REG_WINDOW_LEN, $urandom_range(0, 15));
    r = $urandom_range(0, 3);
    le = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : (r == 2) ? 8'd10 : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 4);
    sep = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : (r == 2) ? 8'd9 :
          (r == 3) ? le : 8'($urandom_range(0, 255));
    write_reg(REG_LINE_END, le);
    write_reg(REG_FIELD_SEP, sep);
    write_reg(REG_HAS_ID, $urandom_range(0, 1));
    write_reg(REG_TAIL_FLUSH, $urandom_range(0, 1));
    // occasionally skip one more line, otherwise leave skipping finished
    if ($urandom_range(0, 3) == 0 && lines_dropped < SKIP_CNT_MAX)
      write_reg(REG_SKIP_LINES, lines_dropped + 1);
    else
      write_reg(REG_SKIP_LINES, $urandom_range(0, lines_dropped));
  endtask

  initial begin
    int unsigned phase_start;
    int unsigned len;
    // reset defaults of the block
    cfg_mirror.window_len = 4;
    cfg_mirror.skip_lines = 1;
    cfg_mirror.has_id     = 1'b1;
    cfg_mirror.tail_flush = 1'b0;
    cfg_mirror.line_end   = 8'd10;
    cfg_mirror.field_sep  = 8'd9;
    lines_dropped = '0;
    in_body       = 1'b0;
    window_bytes  = '0;
    body_len_cnt  = 0;

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Defaults: one skipped line, ID bytes at extremes, repeated separator in body
    queue_byte(8'h41);
    queue_byte(8'd10);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'd9);
    queue_byte(8'h01);
    queue_byte(8'h80);
    queue_byte(8'h7F);
    queue_byte(8'hFE);
    queue_byte(8'd9);
    queue_byte(8'd10);
    settle();

    // Full-width window, then shrink it mid-line
    write_reg(REG_WINDOW_LEN, 8);
    write_reg(REG_TAIL_FLUSH, 1);
    queue_byte(8'd9);
    queue_byte(8'hAA);
    queue_byte(8'hAA);
    queue_byte(8'hAA);
    settle();
    write_reg(REG_WINDOW_LEN, 2);
    queue_byte(8'h55);
    queue_byte(8'h33);
    queue_byte(8'd10);
    // line end with no body: tails from an empty window
    queue_byte(8'd10);
    settle();

    // Separator equal to line end, oversized window length
    write_reg(REG_WINDOW_LEN, 15);
    write_reg(REG_FIELD_SEP, 10);
    queue_byte(8'd10);
    queue_byte(8'd10);
    settle();

    // Skip far, then no skip, window length zero, delimiters at extremes
    write_reg(REG_SKIP_LINES, 255);
    queue_byte(8'd10);
    queue_byte(8'd10);
    settle();
    write_reg(REG_SKIP_LINES, 0);
    write_reg(REG_HAS_ID, 0);
    write_reg(REG_TAIL_FLUSH, 0);
    write_reg(REG_WINDOW_LEN, 0);
    write_reg(REG_LINE_END, 255);
    write_reg(REG_FIELD_SEP, 0);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    settle();
    // raising the skip count resumes dropping lines
    write_reg(REG_SKIP_LINES, 5);
    queue_byte(8'hFF);
    queue_byte(8'hFF);
    queue_byte(8'h12);
    settle();

    // Random phases: mostly well-formed lines, some raw noise
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      pick_random_setup();
      if (ph == 1) squeeze_req = 1'b1;
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < PHASE_BYTES) begin
        if ($urandom_range(0, 9) == 0) begin
          len = $urandom_range(1, 6);
          for (int unsigned i = 0; i < len; i++) queue_byte(8'($urandom_range(0, 255)));
        end else begin
          queue_text_line($urandom_range(0, 3), $urandom_range(0, 12));
        end
      end
      settle();
    end

    if (error_cnt == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
